>>> sv/stuo_pkg.sv
// shared types, constants and helpers for the summer time offset selector
`default_nettype none

package stuo_pkg;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned OFFS_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam int unsigned CENT_W   = 6;
  localparam int unsigned YMOD_W   = 7;
  localparam int unsigned SUM_W    = 9;
  localparam int unsigned RECIP_W  = 13;
  localparam int unsigned PROD_W   = YEAR_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_100  = 13'd5243;
  localparam int unsigned        RECIP_SH   = 19;
  localparam logic [6:0]         CENTURY    = 7'd100;

  localparam logic [MONTH_W-1:0] MONTH_MARCH     = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APRIL     = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_SEPTEMBER = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_OCTOBER   = 4'd10;

  // 31 + (13 * (month + 1)) / 5 + 6, folded into the weekday of the 31st
  localparam logic [SUM_W-1:0] MARCH_BIAS    = 9'd47;
  localparam logic [SUM_W-1:0] OCTOBER_BIAS  = 9'd65;
  localparam logic [DAY_W-1:0] MONTH_END_DAY = 5'd31;

  localparam logic [CFG_IDX_W-1:0] REG_STANDARD_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUMMER_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_HOUR     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUTUMN_HOUR     = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
  } item_t;

  typedef struct packed {
    logic [OFFS_W-1:0] standard_offset;
    logic [OFFS_W-1:0] summer_offset;
    logic [HOUR_W-1:0] spring_hour;
    logic [HOUR_W-1:0] autumn_hour;
  } cfg_t;

  function automatic logic [2:0] mod7(input logic [SUM_W-1:0] x);
    logic [4:0] a;
    logic [3:0] b;
    logic [3:0] r;
    a = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]);
    b = 4'(a[2:0]) + 4'(a[4:3]);
    r = (b >= 4'd7) ? (b - 4'd7) : b;
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/stuo_century.sv
// year split into century and year of century, summed into the weekday term
`default_nettype none

module stuo_century (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire stuo_pkg::item_t          item_in,
  input  wire [stuo_pkg::YEAR_W-1:0]    year_in,
  output stuo_pkg::item_t               item_out,
  output logic [stuo_pkg::SUM_W-1:0]    sum_out
);
  import stuo_pkg::*;

  item_t               s1_item_r;
  logic [YEAR_W-1:0]   s1_year_r;
  logic [CENT_W-1:0]   s1_cent_r;
  item_t               s2_item_r;
  logic [SUM_W-1:0]    s2_sum_r;

  logic [PROD_W-1:0]   prod;
  logic [YEAR_W-1:0]   cent_scaled;
  logic [YEAR_W-1:0]   ymod_full;
  logic [YMOD_W-1:0]   ymod;
  logic [SUM_W-1:0]    sum_nxt;

  assign prod = PROD_W'(year_in) * PROD_W'(RECIP_100);

  always_comb begin
    cent_scaled = YEAR_W'(s1_cent_r) * YEAR_W'(CENTURY);
    ymod_full   = s1_year_r - cent_scaled;
    ymod        = ymod_full[YMOD_W-1:0];
    sum_nxt     = SUM_W'(ymod) + SUM_W'(ymod[YMOD_W-1:2]) + SUM_W'(s1_cent_r[CENT_W-1:2])
                + SUM_W'({s1_cent_r, 2'b00}) + SUM_W'(s1_cent_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_item_r.valid <= 1'b0;
      s2_item_r.valid <= 1'b0;
    end else begin
      s1_item_r.valid <= item_in.valid;
      s2_item_r.valid <= s1_item_r.valid;
    end
    s1_item_r.month <= item_in.month;
    s1_item_r.day   <= item_in.day;
    s1_item_r.hour  <= item_in.hour;
    s1_year_r       <= year_in;
    s1_cent_r       <= prod[RECIP_SH +: CENT_W];
    s2_item_r.month <= s1_item_r.month;
    s2_item_r.day   <= s1_item_r.day;
    s2_item_r.hour  <= s1_item_r.hour;
    s2_sum_r        <= sum_nxt;
  end

  assign item_out = s2_item_r;
  assign sum_out  = s2_sum_r;

endmodule

`default_nettype wire

>>> sv/stuo_lastsun.sv
// day of month of the last sunday in march or october
`default_nettype none

module stuo_lastsun (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire stuo_pkg::item_t         item_in,
  input  wire [stuo_pkg::SUM_W-1:0]    sum_in,
  output stuo_pkg::item_t              item_out,
  output logic [stuo_pkg::DAY_W-1:0]   last_sun_out
);
  import stuo_pkg::*;

  item_t            s3_item_r;
  logic [DAY_W-1:0] s3_last_r;

  logic [SUM_W-1:0] biased;
  logic [2:0]       wday;
  logic [DAY_W-1:0] last_nxt;

  always_comb begin
    biased   = sum_in + ((item_in.month == MONTH_OCTOBER) ? OCTOBER_BIAS : MARCH_BIAS);
    wday     = mod7(biased);
    last_nxt = MONTH_END_DAY - DAY_W'(wday);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_item_r.valid <= 1'b0;
    end else begin
      s3_item_r.valid <= item_in.valid;
    end
    s3_item_r.month <= item_in.month;
    s3_item_r.day   <= item_in.day;
    s3_item_r.hour  <= item_in.hour;
    s3_last_r       <= last_nxt;
  end

  assign item_out     = s3_item_r;
  assign last_sun_out = s3_last_r;

endmodule

`default_nettype wire

>>> sv/stuo_decide.sv
// summer time decision and registered result
`default_nettype none

module stuo_decide (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire stuo_pkg::item_t          item_in,
  input  wire [stuo_pkg::DAY_W-1:0]     last_sun_in,
  input  wire stuo_pkg::cfg_t           cfg,
  output logic                          out_valid,
  output logic [stuo_pkg::OFFS_W-1:0]   out_utc_offset,
  output logic                          out_summer_active
);
  import stuo_pkg::*;

  logic              valid_r;
  logic [OFFS_W-1:0] offset_r;
  logic              summer_r;
  logic              summer_nxt;

  always_comb begin
    summer_nxt = 1'b0;
    if (item_in.month inside {[MONTH_APRIL:MONTH_SEPTEMBER]}) begin
      summer_nxt = 1'b1;
    end else if (item_in.month == MONTH_MARCH) begin
      summer_nxt = (item_in.day > last_sun_in)
                || (item_in.day == last_sun_in && item_in.hour >= cfg.spring_hour);
    end else if (item_in.month == MONTH_OCTOBER) begin
      summer_nxt = (item_in.day < last_sun_in)
                || (item_in.day == last_sun_in && item_in.hour < cfg.autumn_hour);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= item_in.valid;
    end
    summer_r <= summer_nxt;
    offset_r <= summer_nxt ? cfg.summer_offset : cfg.standard_offset;
  end

  assign out_valid         = valid_r;
  assign out_utc_offset    = offset_r;
  assign out_summer_active = summer_r;

endmodule

`default_nettype wire

>>> sv/summer_time_utc_offset_top.sv
// top level of the summer time utc offset selector with its config registers
//
// usage
//   input: drive in_cal_year, in_cal_month, in_cal_day and in_cal_hour with
//   start high; the transfer happens at the clock edge where start is high and
//   busy is low. busy stays low, so one date is taken every cycle.
//   output: each date gives exactly one result, shown for one cycle with
//   out_valid high on out_utc_offset and out_summer_active.
//   pipeline: out_valid rises when the decision register loads the date, once
//   it has passed the century split, weekday sum and last sunday registers.
//   throughput: 1 date per cycle; busy is tied low and nothing feeds back over
//   the four register stages (century split by reciprocal multiply, weekday
//   sum, mod 7 and last sunday, decision).
//   config: write cfg_wdata to register cfg_index when cfg_valid and cfg_ready
//   are high; cfg_ready is always high. index 0 standard offset, 1 summer
//   offset, 2 spring switch hour, 3 autumn switch hour. write only while idle.
//   reset: rst_n low clears the pipeline valid bits and loads offsets 1 and 2
//   and switch hours 2 and 3.
//   stall: the receiver has no stall; results are never held back.
`default_nettype none

module summer_time_utc_offset_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire [stuo_pkg::YEAR_W-1:0]         in_cal_year,
  input  wire [stuo_pkg::MONTH_W-1:0]        in_cal_month,
  input  wire [stuo_pkg::DAY_W-1:0]          in_cal_day,
  input  wire [stuo_pkg::HOUR_W-1:0]         in_cal_hour,
  output logic                               out_valid,
  output logic [stuo_pkg::OFFS_W-1:0]        out_utc_offset,
  output logic                               out_summer_active,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [stuo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [stuo_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import stuo_pkg::*;

  cfg_t             cfg_r;
  item_t            item_in;
  item_t            item_s2;
  item_t            item_s3;
  logic [SUM_W-1:0] sum_s2;
  logic [DAY_W-1:0] last_s3;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    item_in.valid = start & ~busy;
    item_in.month = in_cal_month;
    item_in.day   = in_cal_day;
    item_in.hour  = in_cal_hour;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.standard_offset <= 4'd1;
      cfg_r.summer_offset   <= 4'd2;
      cfg_r.spring_hour     <= 5'd2;
      cfg_r.autumn_hour     <= 5'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STANDARD_OFFSET: cfg_r.standard_offset <= cfg_wdata[OFFS_W-1:0];
        REG_SUMMER_OFFSET:   cfg_r.summer_offset   <= cfg_wdata[OFFS_W-1:0];
        REG_SPRING_HOUR:     cfg_r.spring_hour     <= cfg_wdata[HOUR_W-1:0];
        REG_AUTUMN_HOUR:     cfg_r.autumn_hour     <= cfg_wdata[HOUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  stuo_century u_century (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_in  (item_in),
    .year_in  (in_cal_year),
    .item_out (item_s2),
    .sum_out  (sum_s2)
  );

  stuo_lastsun u_lastsun (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_in      (item_s2),
    .sum_in       (sum_s2),
    .item_out     (item_s3),
    .last_sun_out (last_s3)
  );

  stuo_decide u_decide (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_in           (item_s3),
    .last_sun_in       (last_s3),
    .cfg               (cfg_r),
    .out_valid         (out_valid),
    .out_utc_offset    (out_utc_offset),
    .out_summer_active (out_summer_active)
  );

endmodule

`default_nettype wire
